/* rtl/skt_pkg.sv */
// Shared types and constants of the sorted key table.
`default_nettype none
package skt_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = 6;
  localparam int CNT_W  = 7;
  localparam int KEY_W  = 32;
  localparam int PAY_W  = 32;
  localparam int REF_W  = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_KEY   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DUP       = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_PROBE,
    BS_CMP,
    BS_SHIFT_UP,
    BS_INSERT,
    BS_SHIFT_DN,
    BS_FETCH
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic              bad_key;
    logic              auto_key;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  pay;
    logic [ADDR_W-1:0] slot;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/skt_front.sv */
// Front end: accept input words and classify them into commands.
`default_nettype none
module skt_front import skt_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] agent_key_i,
  input  logic [31:0] payload_i,
  input  logic [5:0]  slot_index_i,
  input  logic        q_full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic key_zero;

  assign key_zero   = (agent_key_i == '0);
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.op       = op_e'(action_i);
    cmd_o.key      = agent_key_i;
    cmd_o.pay      = payload_i;
    cmd_o.slot     = slot_index_i;
    // remove and find never accept key zero
    cmd_o.bad_key  = key_zero && (cmd_o.op == OP_REMOVE || cmd_o.op == OP_FIND);
    cmd_o.auto_key = key_zero && (cmd_o.op == OP_ADD);
  end

endmodule
`default_nettype wire

/* rtl/skt_queue.sv */
// Two-entry command queue between front and back end.
`default_nettype none
module skt_queue import skt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t       slots_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/skt_back.sv */
// Back end: binary search, shifting insert and remove, result register.
`default_nettype none
module skt_back import skt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  input  logic              cfg_wr_i,
  input  logic [CNT_W-1:0]  cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [KEY_W-1:0]  key_out_o,
  output logic [PAY_W-1:0]  payload_out_o,
  output logic [CNT_W-1:0]  entry_count_o,
  output logic [REF_W-1:0]  refused_count_o
);

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [PAY_W-1:0] pay_mem [DEPTH];

  back_state_e       state_q, state_d;
  op_e               op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [PAY_W-1:0]  pay_q, pay_d;
  logic [CNT_W-1:0]  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, i_q, i_d;
  logic              hit_q, hit_d, pend_q, pend_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic [CNT_W-1:0]  fill_q, fill_d, cap_q, cap_d;
  logic [KEY_W-1:0]  next_key_q, next_key_d;
  logic [REF_W-1:0]  refusals_q, refusals_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [KEY_W-1:0]  out_key_q, out_key_d;
  logic [PAY_W-1:0]  out_pay_q, out_pay_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic [REF_W-1:0]  out_ref_q, out_ref_d;

  logic              start, lo_lt_hi, out_load, full_now, more_dn;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid_w, cfg_sat;
  logic [KEY_W-1:0]  rd_key_q;
  logic [PAY_W-1:0]  rd_pay_q;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en;
  logic [KEY_W-1:0]  wr_key;
  logic [PAY_W-1:0]  wr_pay;

  assign start    = (state_q == BS_IDLE) && q_valid_i && !out_valid_q;
  assign pop_o    = start;
  assign lo_lt_hi = (lo_q < hi_q);
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w    = mid_sum[CNT_W:1];
  assign full_now = (fill_q >= cap_q) || (fill_q >= CNT_W'(DEPTH));
  assign more_dn  = ({1'b0, i_q} + 1'b1) < {1'b0, fill_q};
  assign cfg_sat  = (cfg_data_i > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg_data_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (start) begin
          unique case (cmd_i.op)
            OP_ADD:               state_d = BS_PROBE;
            OP_REMOVE, OP_FIND:   state_d = cmd_i.bad_key ? BS_IDLE : BS_PROBE;
            OP_READ: begin
              state_d = ({1'b0, cmd_i.slot} >= fill_q) ? BS_IDLE : BS_FETCH;
            end
            default:              state_d = BS_IDLE;
          endcase
        end
      end
      BS_PROBE: begin
        if (lo_lt_hi) begin
          state_d = BS_CMP;
        end else begin
          unique case (op_q)
            OP_ADD:    state_d = (hit_q || full_now) ? BS_IDLE : BS_SHIFT_UP;
            OP_REMOVE: state_d = hit_q ? BS_SHIFT_DN : BS_IDLE;
            OP_FIND:   state_d = hit_q ? BS_FETCH : BS_IDLE;
            default:   state_d = BS_IDLE;
          endcase
        end
      end
      BS_CMP:      state_d = BS_PROBE;
      BS_SHIFT_UP: state_d = (i_q > lo_q) ? BS_SHIFT_UP : BS_INSERT;
      BS_INSERT:   state_d = BS_IDLE;
      BS_SHIFT_DN: state_d = more_dn ? BS_SHIFT_DN : BS_IDLE;
      BS_FETCH:    state_d = BS_IDLE;
      default:     state_d = BS_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    pay_d        = pay_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    i_d          = i_q;
    hit_d        = hit_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    fill_d       = fill_q;
    cap_d        = cap_q;
    next_key_d   = next_key_q;
    refusals_d   = refusals_q;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_pay_d    = out_pay_q;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = pend_addr_q;
    wr_key       = rd_key_q;
    wr_pay       = rd_pay_q;

    if (cfg_wr_i && (cfg_sat > cap_q)) begin
      cap_d = cfg_sat;
    end

    unique case (state_q)
      BS_IDLE: begin
        if (start) begin
          op_d  = cmd_i.op;
          pay_d = cmd_i.pay;
          key_d = cmd_i.auto_key ? next_key_q : cmd_i.key;
          lo_d  = '0;
          hi_d  = fill_q;
          hit_d = 1'b0;
          if (cmd_i.op == OP_ADD) begin
            // the key counter moves before the add is checked
            if (cmd_i.auto_key) begin
              next_key_d = next_key_q + 1'b1;
            end else if (cmd_i.key >= next_key_q) begin
              next_key_d = cmd_i.key + 1'b1;
            end
          end
          if (cmd_i.bad_key) begin
            out_load     = 1'b1;
            out_status_d = ST_BAD_KEY;
            out_key_d    = '0;
            out_pay_d    = '0;
          end else if (cmd_i.op == OP_READ) begin
            rd_addr = cmd_i.slot;
            if ({1'b0, cmd_i.slot} >= fill_q) begin
              out_load     = 1'b1;
              out_status_d = ST_NOT_FOUND;
              out_key_d    = '0;
              out_pay_d    = '0;
            end
          end
        end
      end
      BS_PROBE: begin
        if (lo_lt_hi) begin
          rd_addr = mid_w[ADDR_W-1:0];
          mid_d   = mid_w;
        end else begin
          out_key_d = '0;
          out_pay_d = '0;
          rd_addr   = lo_q[ADDR_W-1:0];
          i_d       = (op_q == OP_ADD) ? fill_q : lo_q;
          pend_d    = 1'b0;
          unique case (op_q)
            OP_ADD: begin
              if (hit_q) begin
                out_load     = 1'b1;
                out_status_d = ST_DUP;
              end else if (full_now) begin
                refusals_d   = refusals_q + 1'b1;
                out_load     = 1'b1;
                out_status_d = ST_FULL;
              end
            end
            OP_REMOVE, OP_FIND: begin
              if (!hit_q) begin
                out_load     = 1'b1;
                out_status_d = ST_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
      end
      BS_CMP: begin
        if (rd_key_q < key_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        if (rd_key_q == key_q) begin
          hit_d = 1'b1;
        end
      end
      BS_SHIFT_UP: begin
        // write back the entry read last cycle one place up
        wr_en = pend_q;
        if (i_q > lo_q) begin
          rd_addr     = ADDR_W'(i_q - 1'b1);
          pend_d      = 1'b1;
          pend_addr_d = i_q[ADDR_W-1:0];
          i_d         = i_q - 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      BS_INSERT: begin
        wr_en        = 1'b1;
        wr_addr      = lo_q[ADDR_W-1:0];
        wr_key       = key_q;
        wr_pay       = pay_q;
        fill_d       = fill_q + 1'b1;
        out_load     = 1'b1;
        out_status_d = ST_OK;
        out_key_d    = key_q;
        out_pay_d    = '0;
      end
      BS_SHIFT_DN: begin
        wr_en = pend_q;
        if (more_dn) begin
          rd_addr     = ADDR_W'(i_q + 1'b1);
          pend_d      = 1'b1;
          pend_addr_d = i_q[ADDR_W-1:0];
          i_d         = i_q + 1'b1;
        end else begin
          pend_d       = 1'b0;
          fill_d       = fill_q - 1'b1;
          out_load     = 1'b1;
          out_status_d = ST_OK;
          out_key_d    = '0;
          out_pay_d    = '0;
        end
      end
      BS_FETCH: begin
        out_load     = 1'b1;
        out_status_d = ST_OK;
        out_key_d    = rd_key_q;
        out_pay_d    = rd_pay_q;
      end
      default: ;
    endcase

    out_cnt_d   = out_load ? fill_d : out_cnt_q;
    out_ref_d   = out_load ? refusals_d : out_ref_q;
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      fill_q      <= '0;
      cap_q       <= '0;
      next_key_q  <= KEY_W'(1);
      refusals_q  <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cap_q       <= cap_d;
      next_key_q  <= next_key_d;
      refusals_q  <= refusals_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    pay_q        <= pay_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    i_q          <= i_d;
    hit_q        <= hit_d;
    pend_addr_q  <= pend_addr_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_pay_q    <= out_pay_d;
    out_cnt_q    <= out_cnt_d;
    out_ref_q    <= out_ref_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
    rd_key_q <= key_mem[rd_addr];
    rd_pay_q <= pay_mem[rd_addr];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign key_out_o       = out_key_q;
  assign payload_out_o   = out_pay_q;
  assign entry_count_o   = out_cnt_q;
  assign refused_count_o = out_ref_q;

endmodule
`default_nettype wire

/* rtl/sorted_key_table_unit.sv */
// Top level of the sorted key table.
//
// Holds up to 64 (key, payload) entries in ascending key order in two
// 64-word memories. Input words (action, agent_key, payload, slot_index)
// arrive on a valid/stall channel; each produces exactly one result word
// (status, key_out, payload_out, entry_count, refused_count) on an output
// valid/stall channel. A one-word write channel (valid/ready, always ready)
// raises the capacity limit; write it only while the block is idle.
// The front end classifies words into a two-entry queue, so it takes up to
// two words while the back end works or a result waits on a stalled receiver.
// In the back end, read-at fetches the slot directly and find runs a binary
// search; add and remove also shift each entry behind the slot one place
// through the single memory read port. One word is worked at a time.
// Reset empties the table, sets the key counter to one and clears the
// refusal count and capacity limit. While the receiver stalls the result
// register holds its word and the back end starts no new word.
`default_nettype none
module sorted_key_table_unit import skt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] agent_key_i,
  input  logic [31:0] payload_i,
  input  logic [5:0]  slot_index_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] key_out_o,
  output logic [31:0] payload_out_o,
  output logic [6:0]  entry_count_o,
  output logic [31:0] refused_count_o
);

  cmd_t front_cmd, queue_cmd;
  logic push, pop, q_full, q_valid;

  // capacity register always accepts its write, but only a higher value raises it
  assign cfg_ready_o = 1'b1;

  skt_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .agent_key_i  (agent_key_i),
    .payload_i    (payload_i),
    .slot_index_i (slot_index_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  skt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (queue_cmd)
  );

  skt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .cmd_i           (queue_cmd),
    .pop_o           (pop),
    .cfg_wr_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .key_out_o       (key_out_o),
    .payload_out_o   (payload_out_o),
    .entry_count_o   (entry_count_o),
    .refused_count_o (refused_count_o)
  );

endmodule
`default_nettype wire

/* rtl/skt_checker.sv */
// Port-level checks of the sorted key table, bound to the top level.
`default_nettype none
module skt_checker import skt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [31:0] key_out_o,
  input logic [6:0]  entry_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped under stall");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_FULL)
    else $error("status code out of range");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= 7'(DEPTH))
    else $error("entry count beyond depth");

  a_fail_no_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> key_out_o == '0)
    else $error("failed word carries a key");

endmodule

bind sorted_key_table_unit skt_checker u_skt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .key_out_o     (key_out_o),
  .entry_count_o (entry_count_o)
);
`default_nettype wire
